// ===== hdl/skvis_pkg.sv =====
package skvis_pkg;

    // field widths fixed by the pair format
    localparam int unsigned KEY_W = 32;
    localparam int unsigned ID_W  = 31;

    // input beat: one (distance, node ordinal) pair
    typedef struct packed {
        logic [KEY_W-1:0] distance;
        logic [ID_W-1:0]  node_id;
        logic             last;
    } t_in_beat;

    // output beat: one ranked pair
    typedef struct packed {
        logic [KEY_W-1:0] sorted_distance;
        logic [ID_W-1:0]  sorted_node_id;
        logic             end_of_run;
        logic             overflowed;
    } t_out_beat;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // collect pairs, then drain them in order
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

endpackage

// ===== hdl/skvis_cell.sv =====
module skvis_cell (
    input  logic                          i_clk,
    input  skvis_pkg::t_cell_ctrl         i_ctrl,
    input  logic                          i_occupied,
    input  logic [skvis_pkg::KEY_W-1:0]   i_new_key,
    input  logic [skvis_pkg::ID_W-1:0]    i_new_id,
    input  logic                          i_left_greater,
    input  logic [skvis_pkg::KEY_W-1:0]   i_left_key,
    input  logic [skvis_pkg::ID_W-1:0]    i_left_id,
    input  logic [skvis_pkg::KEY_W-1:0]   i_right_key,
    input  logic [skvis_pkg::ID_W-1:0]    i_right_id,
    output logic                          o_greater,
    output logic [skvis_pkg::KEY_W-1:0]   o_key,
    output logic [skvis_pkg::ID_W-1:0]    o_id
);

    logic [skvis_pkg::KEY_W-1:0] r_key;
    logic [skvis_pkg::KEY_W-1:0] n_key;
    logic [skvis_pkg::ID_W-1:0]  r_id;
    logic [skvis_pkg::ID_W-1:0]  n_id;

    // an empty cell counts as greater, so the new pair lands on the first free one
    // strict compare keeps equal keys in arrival order
    assign o_greater = !i_occupied || (r_key > i_new_key);

    // insert: move right if displaced, take the new pair at the boundary
    always_comb begin
        n_key = r_key;
        n_id  = r_id;
        priority if (i_ctrl.insert && o_greater) begin
            if (i_left_greater) begin
                n_key = i_left_key;
                n_id  = i_left_id;
            end else begin
                n_key = i_new_key;
                n_id  = i_new_id;
            end
        end else if (i_ctrl.shift) begin
            n_key = i_right_key;
            n_id  = i_right_id;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

    assign o_key = r_key;
    assign o_id  = r_id;

endmodule

// ===== hdl/stable_key_value_insertion_sort_core.sv =====
// Stable ascending insertion sort of (distance, node ordinal) pairs.
// Input channel: i_in_valid / o_in_ready carry i_in_beat, one pair a beat.
// Each accepted pair is placed in a row of LIST_DEPTH cells in the same
// cycle, so pairs are taken back to back at one per cycle while collecting.
// Pairs with equal distance keep arrival order. Once LIST_DEPTH pairs are
// held, further pairs are dropped and the overflowed flag is set for the set.
// A beat with last set closes the set: from the next cycle the held pairs
// leave on o_out_valid / i_out_ready, lowest distance first, one per cycle
// while the receiver is ready, straight from the head cell register, with
// end_of_run on the final beat. During the drain o_in_ready is low, so no
// new pair is taken until the held pairs have left; the drain goes through
// the single head-cell output, shifting the row one place per beat.
// If the receiver stalls, the head beat holds and the row stays still.
// Synchronous active-low reset empties the row (held count and drop flag
// to zero); cell contents are not cleared and are never read
// before being written.
module stable_key_value_insertion_sort_core #(
    parameter int unsigned LIST_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  skvis_pkg::t_in_beat   i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output skvis_pkg::t_out_beat  o_out_beat
);

    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

    skvis_pkg::t_state      r_state;
    skvis_pkg::t_state      n_state;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_drop;
    logic                   n_drop;
    skvis_pkg::t_cell_ctrl  ctrl;

    logic                   in_fire;
    logic                   out_fire;
    logic                   full;

    logic [LIST_DEPTH-1:0]  occupied;
    logic [LIST_DEPTH-1:0]  greater;
    logic [skvis_pkg::KEY_W-1:0] cell_key [LIST_DEPTH];
    logic [skvis_pkg::ID_W-1:0]  cell_id  [LIST_DEPTH];

    assign full     = (r_count == CNT_W'(LIST_DEPTH));
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // state, count and drop flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvis_pkg::ST_FILL;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // next state and cell commands
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            skvis_pkg::ST_FILL: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                    if (i_in_beat.last) begin
                        n_state = skvis_pkg::ST_DRAIN;
                    end
                end
            end
            skvis_pkg::ST_DRAIN: begin
                o_out_valid = 1'b1;
                if (out_fire) begin
                    ctrl.shift = 1'b1;
                    n_count    = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = skvis_pkg::ST_FILL;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = skvis_pkg::ST_FILL;
            end
        endcase
    end

    // row of cells, each linked to its neighbours; the end cells take the input pair instead
    for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
        logic                        left_greater;
        logic [skvis_pkg::KEY_W-1:0] left_key;
        logic [skvis_pkg::ID_W-1:0]  left_id;
        logic [skvis_pkg::KEY_W-1:0] right_key;
        logic [skvis_pkg::ID_W-1:0]  right_id;

        assign occupied[gi] = (r_count > CNT_W'(gi));

        if (gi == 0) begin : g_head
            assign left_greater = 1'b0;
            assign left_key     = i_in_beat.distance;
            assign left_id      = i_in_beat.node_id;
        end else begin : g_body
            assign left_greater = greater[gi-1];
            assign left_key     = cell_key[gi-1];
            assign left_id      = cell_id[gi-1];
        end

        if (gi == LIST_DEPTH - 1) begin : g_tail
            assign right_key = i_in_beat.distance;
            assign right_id  = i_in_beat.node_id;
        end else begin : g_inner
            assign right_key = cell_key[gi+1];
            assign right_id  = cell_id[gi+1];
        end

        skvis_cell u_cell (
            .i_clk          (i_clk),
            .i_ctrl         (ctrl),
            .i_occupied     (occupied[gi]),
            .i_new_key      (i_in_beat.distance),
            .i_new_id       (i_in_beat.node_id),
            .i_left_greater (left_greater),
            .i_left_key     (left_key),
            .i_left_id      (left_id),
            .i_right_key    (right_key),
            .i_right_id     (right_id),
            .o_greater      (greater[gi]),
            .o_key          (cell_key[gi]),
            .o_id           (cell_id[gi])
        );
    end

    // output beat comes from the head cell
    assign o_out_beat.sorted_distance = cell_key[0];
    assign o_out_beat.sorted_node_id  = cell_id[0];
    assign o_out_beat.end_of_run      = (r_count == CNT_W'(1));
    assign o_out_beat.overflowed      = r_drop;

    // a closing beat starts the drain in the next cycle
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_beat.last) |=> o_out_valid)
        else $error("drain did not start after last beat");

    // held count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LIST_DEPTH))
        else $error("held count beyond depth");

    // drop flag only rises on a beat taken while full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drop) |-> ($past(full) && $past(in_fire)))
        else $error("drop flag set while not full");

    // no output beat right after the end of a run
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out_beat.end_of_run) |=> !o_out_valid)
        else $error("output continued past end of run");

    // drained keys never decrease
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_out_beat.end_of_run) |=>
            (o_out_valid &&
             (o_out_beat.sorted_distance >= $past(o_out_beat.sorted_distance))))
        else $error("output keys out of order");

endmodule

// ===== bench/stable_key_value_insertion_sort_core_tb.sv =====
module stable_key_value_insertion_sort_core_tb;

    localparam int SORT_DEPTH = 64;

    // clock, reset and block ports
    logic                 i_clk       = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    skvis_pkg::t_in_beat  in_beat     = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    skvis_pkg::t_out_beat out_beat;

    // pairs waiting to be sent, pairs held by the sort model, beats still due
    skvis_pkg::t_in_beat  pairs_to_send[$];
    skvis_pkg::t_in_beat  held_pairs[$];
    skvis_pkg::t_out_beat awaited_beats[$];
    logic                 pairs_dropped  = 1'b0;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        mismatch_count = 0;

    stable_key_value_insertion_sort_core #(
        .LIST_DEPTH (SORT_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always #5 i_clk = ~i_clk;

    // stable insertion of one accepted pair; on last the whole set is ranked
    function automatic void rank_pair(skvis_pkg::t_in_beat pair);
        int                   pos;
        skvis_pkg::t_out_beat ranked;
        if (held_pairs.size() >= SORT_DEPTH) begin
            pairs_dropped = 1'b1;
        end else begin
            pos = held_pairs.size();
            // equal distances stay behind earlier arrivals
            while (pos > 0 && held_pairs[pos-1].distance > pair.distance)
                pos--;
            held_pairs.insert(pos, pair);
        end
        if (pair.last) begin
            foreach (held_pairs[k]) begin
                ranked.sorted_distance = held_pairs[k].distance;
                ranked.sorted_node_id  = held_pairs[k].node_id;
                ranked.end_of_run      = (k == held_pairs.size() - 1);
                ranked.overflowed      = pairs_dropped;
                awaited_beats.push_back(ranked);
            end
            held_pairs.delete();
            pairs_dropped = 1'b0;
        end
    endfunction

    function automatic void flag_error(string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $time, msg);
        mismatch_count++;
    endfunction

    // compare one output beat with the oldest ranked pair due
    function automatic void check_beat(skvis_pkg::t_out_beat got);
        skvis_pkg::t_out_beat want;
        if (awaited_beats.size() == 0) begin
            flag_error($sformatf("unexpected beat dist=%h id=%h eor=%b ovf=%b",
                got.sorted_distance, got.sorted_node_id, got.end_of_run,
                got.overflowed));
        end else begin
            want = awaited_beats.pop_front();
            if (got.sorted_distance !== want.sorted_distance ||
                got.sorted_node_id  !== want.sorted_node_id  ||
                got.end_of_run      !== want.end_of_run      ||
                got.overflowed      !== want.overflowed) begin
                flag_error($sformatf(
                    "mismatch: expected dist=%h id=%h eor=%b ovf=%b, got dist=%h id=%h eor=%b ovf=%b",
                    want.sorted_distance, want.sorted_node_id, want.end_of_run,
                    want.overflowed, got.sorted_distance, got.sorted_node_id,
                    got.end_of_run, got.overflowed));
            end
        end
    endfunction

    // input driver: take the accepted beat, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                rank_pair(in_beat);
            if (!in_valid || in_ready) begin
                if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat  <= pairs_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor with random back-pressure
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready)
            check_beat(out_beat);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_pair(logic [skvis_pkg::KEY_W-1:0] key_val,
                             logic [skvis_pkg::ID_W-1:0] id, logic fin);
        skvis_pkg::t_in_beat b;
        b.distance = key_val;
        b.node_id  = id;
        b.last     = fin;
        pairs_to_send.push_back(b);
    endtask

    // mix of extremes, a small pool of repeated distances and full-range values
    function automatic logic [skvis_pkg::KEY_W-1:0] pick_distance();
        logic [skvis_pkg::KEY_W-1:0] d;
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = '1;
            2, 3, 4: d = (32'($urandom_range(3)) << 16) | 32'h8000;
            default: d = $urandom;
        endcase
        return d;
    endfunction

    function automatic logic [skvis_pkg::ID_W-1:0] pick_id();
        logic [skvis_pkg::ID_W-1:0] id;
        case ($urandom_range(7))
            0:       id = '0;
            1:       id = '1;
            default: id = skvis_pkg::ID_W'($urandom);
        endcase
        return id;
    endfunction

    task automatic queue_set(int set_len);
        for (int i = 0; i < set_len; i++)
            push_pair(pick_distance(), pick_id(), i == set_len - 1);
    endtask

    // random sets, mostly short, now and then around or past the depth
    task automatic queue_random_sets(int n_pairs);
        int sent;
        int r;
        sent = 0;
        while (sent < n_pairs) begin
            r = $urandom_range(99);
            if (r < 6)
                r = $urandom_range(60, 70);
            else if (r < 15)
                r = 1;
            else
                r = $urandom_range(2, 10);
            queue_set(r);
            sent += r;
        end
    endtask

    // hold off until every queued pair is sent and every ranked beat is back
    task automatic wait_drained();
        while (pairs_to_send.size() != 0 || in_valid || awaited_beats.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // no idling: directed sets first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_pair('1, '1, 1'b1);
        push_pair('0, '0, 1'b1);
        // descending arrivals
        for (int i = 0; i < 5; i++)
            push_pair(32'(5 - i) << 16, skvis_pkg::ID_W'(i + 1), i == 4);
        // equal distances around smaller and larger keys
        push_pair(32'h0001_8000, 31'd10, 1'b0);
        push_pair(32'h0000_8000, 31'd11, 1'b0);
        push_pair(32'h0001_8000, 31'd12, 1'b0);
        push_pair('1,            31'd13, 1'b0);
        push_pair(32'h0001_8000, 31'd14, 1'b0);
        push_pair('0,            31'd15, 1'b1);
        // already ascending
        push_pair('0,                  31'd20, 1'b0);
        push_pair(32'h0000_0001,       31'd21, 1'b0);
        push_pair('1,                  31'd22, 1'b1);
        // exactly full, no drop
        queue_set(SORT_DEPTH);
        queue_random_sets(20);
        wait_drained();

        // sender mostly idle; one over-full set where the closing pair is dropped
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        queue_set(SORT_DEPTH + 1);
        queue_random_sets(20);
        wait_drained();

        // receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        queue_random_sets(70);
        wait_drained();

        // light idling on both sides
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random_sets(70);
        wait_drained();

        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end

endmodule
